FILE: rtl/clws_pkg.sv
// ----------------------------------------------------------------------------
// clws_pkg: shared types and constants of the lattice walker step unit
// Generator constants, register indexes, hexagonal step tables and the
// item record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package clws_pkg;

  // Widest register on the configuration port.
  localparam int unsigned CFG_DATA_W = 54;
  localparam int unsigned CFG_INDEX_W = 3;

  // Largest channel width used; wider register values are clamped to it.
  localparam int unsigned MAX_WIDTH = 16;

  // Default depth of the queue between front and back end.
  localparam int unsigned CLWS_QUEUE_DEPTH = 2;

  // Internal transverse coordinate width (holds -31..31 and one step past).
  localparam int unsigned COORD_W = 7;

  localparam logic [63:0] GOLD      = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] GOLD2     = 64'h3C6EF372FE94F82A;
  localparam logic [63:0] MIX_C1    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_C2    = 64'h94D049BB133111EB;
  localparam logic [63:0] SEED_SALT = 64'hA5A5A5A5DEADBEEF;
  localparam logic [47:0] COUNT_MAX = 48'hFFFFFFFFFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GEOMETRY    = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_FORWARD     = 3'd2,
    REG_BACKWARD    = 3'd3,
    REG_TRANSVERSE  = 3'd4
  } cfg_reg_t;

  // Item modes and geometries.
  localparam logic MODE_START = 1'b0;
  localparam logic GEOM_CUBIC = 1'b0;

  // Directions.
  localparam logic [2:0] DIR_FORWARD  = 3'd0;
  localparam logic [2:0] DIR_BACKWARD = 3'd1;
  localparam logic [2:0] DIR_A_UP     = 3'd2;
  localparam logic [2:0] DIR_A_DOWN   = 3'd3;
  localparam logic [2:0] DIR_B_UP     = 3'd4;
  localparam logic [2:0] DIR_B_DOWN   = 3'd5;
  localparam logic [2:0] CAP_CUBIC    = 3'd5;
  localparam logic [2:0] CAP_HEX      = 3'd7;

  // One classified item in the queue.
  typedef struct packed {
    logic        is_start;
    logic [63:0] key;
  } q_item_t;

  // First half of a splitmix round after the constant add.
  function automatic logic [63:0] xs30(input logic [63:0] t);
    xs30 = t ^ (t >> 30);
  endfunction

  // Hexagonal step tables, indexed by direction minus two.
  function automatic logic signed [1:0] hex_di(input logic [2:0] k);
    case (k)
      3'd0, 3'd4: hex_di = 2'sd1;
      3'd1, 3'd5: hex_di = -2'sd1;
      default:    hex_di = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] hex_dj(input logic [2:0] k);
    case (k)
      3'd2, 3'd5: hex_dj = 2'sd1;
      3'd3, 3'd4: hex_dj = -2'sd1;
      default:    hex_dj = 2'sd0;
    endcase
  endfunction

endpackage

FILE: rtl/clws_front.sv
// ----------------------------------------------------------------------------
// clws_front: input stage of the walker step unit
// Registers each incoming item, classifies it as a start or a step and
// hands it to the queue.
// ----------------------------------------------------------------------------
module clws_front import clws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [63:0] walker_key,
  output logic        push,
  output q_item_t     push_item,
  input  logic        push_ready
);

  logic    held;
  q_item_t item;

  // The stage frees up whenever its item moves into the queue.
  assign in_ready  = !held || push_ready;
  assign push      = held;
  assign push_item = item;

  // Hold one classified item.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  // Classification of the incoming item.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.is_start <= (mode == MODE_START);
      item.key      <= walker_key;
    end
  end

endmodule

FILE: rtl/clws_queue.sv
// ----------------------------------------------------------------------------
// clws_queue: short item queue between front and back end
// A small first-in first-out buffer so either side can stall alone.
// ----------------------------------------------------------------------------
module clws_queue import clws_pkg::*; #(
  parameter int unsigned DEPTH = CLWS_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  q_item_t push_item,
  output logic    push_ready,
  output logic    pop_valid,
  output q_item_t pop_item,
  input  logic    pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  q_item_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: rtl/clws_back.sv
// ----------------------------------------------------------------------------
// clws_back: execution sequencer of the walker step unit
// Seeds the generator through a shared 32x32 multiplier, draws and
// classifies each step, moves the walker and registers the result.
// ----------------------------------------------------------------------------
module clws_back import clws_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_valid,
  input  q_item_t                q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [63:0]     position_x,
  output logic signed [4:0]      coord_a,
  output logic signed [4:0]      coord_b,
  output logic [2:0]             direction,
  output logic [63:0]            site_key,
  output logic                   site_changed,
  output logic [47:0]            step_count
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MUL1  = 8'b00000010,
    S_MUL2  = 8'b00000100,
    S_PREP  = 8'b00001000,
    S_CLASS = 8'b00010000,
    S_MULK  = 8'b00100000,
    S_MOVE  = 8'b01000000,
    S_KEY   = 8'b10000000
  } state_t;

  // Unit step on the internal coordinate width.
  localparam logic signed [COORD_W-1:0] C_ONE = COORD_W'(1);

  // Configuration registers.
  logic        geometry;
  logic [4:0]  channel_width;
  logic [53:0] forward_threshold;
  logic [53:0] backward_threshold;
  logic [34:0] transverse_scale;

  // Walker and generator state.
  logic [63:0]               rng [4];
  logic [63:0]               walker_x;
  logic signed [COORD_W-1:0] walker_a;
  logic signed [COORD_W-1:0] walker_b;
  logic [63:0]               last_key;
  logic [47:0]               jump_count;

  // Sequencer registers.
  state_t      state;
  logic [2:0]  ph;
  logic [2:0]  seed_idx;
  logic        is_start;
  logic [63:0] z_run;
  logic [63:0] mx;
  logic [52:0] u;
  logic [2:0]  dir;
  logic [63:0] prod;
  logic [87:0] acc;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      geometry           <= GEOM_CUBIC;
      channel_width      <= 5'd1;
      forward_threshold  <= '0;
      backward_threshold <= '0;
      transverse_scale   <= 35'd25769803776;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GEOMETRY:   geometry           <= cfg_data[0];
        REG_WIDTH:      channel_width      <= cfg_data[4:0];
        REG_FORWARD:    forward_threshold  <= cfg_data[53:0];
        REG_BACKWARD:   backward_threshold <= cfg_data[53:0];
        REG_TRANSVERSE: transverse_scale   <= cfg_data[34:0];
        default: ;
      endcase
    end
  end

  // Effective channel width, clamped to 1..MAX_WIDTH.
  logic [4:0] eff_w;
  always_comb begin
    if (channel_width == '0) begin
      eff_w = 5'd1;
    end else if (32'(channel_width) > MAX_WIDTH) begin
      eff_w = 5'(MAX_WIDTH);
    end else begin
      eff_w = channel_width;
    end
  end

  logic signed [COORD_W-1:0] w_s;
  assign w_s = $signed({{(COORD_W-5){1'b0}}, eff_w});

  // Shared multiplier operand selection: low/high halves by phase.
  logic [63:0] mb;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  always_comb begin
    if (state == S_MUL1) begin
      mb = MIX_C1;
    end else if (state == S_MUL2) begin
      mb = MIX_C2;
    end else begin
      mb = {29'b0, transverse_scale};
    end
    mul_a = ph[1] ? mx[63:32] : mx[31:0];
    mul_b = ph[0] ? mb[63:32] : mb[31:0];
  end

  // Accumulation of the product registered in the previous phase.
  logic [87:0] acc_sum;
  always_comb begin
    case (ph)
      3'd1:    acc_sum = acc + 88'(prod);
      3'd4:    acc_sum = acc + (88'(prod) << 64);
      default: acc_sum = acc + (88'(prod) << 32);
    endcase
  end

  // Generator output and next state for a step.
  logic [63:0] rsum;
  logic [63:0] rout;
  logic [63:0] n0, n1, n2, n3;
  always_comb begin
    rsum = rng[0] + rng[3];
    rout = {rsum[40:0], rsum[63:41]} + rng[0];
    n2   = rng[2] ^ rng[0];
    n3   = rng[3] ^ rng[1];
    n1   = rng[1] ^ n2;
    n0   = rng[0] ^ n3;
  end

  // Splitmix finishing values.
  logic [63:0] z2;
  logic [63:0] z3;
  logic [63:0] smix;
  assign z2   = acc_sum[63:0];
  assign z3   = acc_sum[63:0];
  assign smix = z3 ^ (z3 >> 31);

  // Transverse direction from the scaled remainder.
  logic [2:0] kval;
  logic [2:0] cap;
  logic [2:0] dir_t;
  always_comb begin
    kval  = acc_sum[87:85];
    cap   = (geometry == GEOM_CUBIC) ? CAP_CUBIC : CAP_HEX;
    dir_t = (kval > cap - 3'd2) ? cap : kval + 3'd2;
  end

  // Walker move for the chosen direction.
  logic signed [COORD_W-1:0] a_next;
  logic signed [COORD_W-1:0] b_next;
  logic signed [COORD_W-1:0] ni;
  logic signed [COORD_W-1:0] nj;
  logic signed [COORD_W:0]   nij;
  logic [COORD_W+1:0]        dsum;
  logic [2:0]                hk;
  always_comb begin
    a_next = walker_a;
    b_next = walker_b;
    hk     = dir - 3'd2;
    ni     = walker_a + COORD_W'(hex_di(hk));
    nj     = walker_b + COORD_W'(hex_dj(hk));
    nij    = (COORD_W+1)'(ni) + (COORD_W+1)'(nj);
    dsum   = (COORD_W+2)'(ni < 0 ? -ni : ni) + (COORD_W+2)'(nj < 0 ? -nj : nj)
           + (COORD_W+2)'(nij < 0 ? -nij : nij);
    if (dir != DIR_FORWARD && dir != DIR_BACKWARD) begin
      if (geometry == GEOM_CUBIC) begin
        case (dir)
          DIR_A_UP:   a_next = (walker_a < 0 || walker_a + 1 >= w_s) ? '0 : walker_a + C_ONE;
          DIR_A_DOWN: a_next = (walker_a <= 0 || walker_a > w_s) ? w_s - C_ONE
                                                                 : walker_a - C_ONE;
          DIR_B_UP:   b_next = (walker_b < 0 || walker_b + 1 >= w_s) ? '0 : walker_b + C_ONE;
          default:    b_next = (walker_b <= 0 || walker_b > w_s) ? w_s - C_ONE
                                                                 : walker_b - C_ONE;
        endcase
      end else if ((dsum >> 1) < (COORD_W+2)'(eff_w)) begin
        a_next = ni;
        b_next = nj;
      end
    end
  end

  // Site key of the current walker position.
  logic signed [17:0] idx;
  logic signed [17:0] rr;
  logic [31:0]        idx32;
  logic [63:0]        key;
  always_comb begin
    rr = 18'(eff_w) - 18'sd1;
    if (geometry == GEOM_CUBIC) begin
      idx = 18'(walker_a) * 18'(w_s) + 18'(walker_b);
    end else begin
      idx = (18'(walker_a) + rr) * (18'(eff_w) * 18'sd2 - 18'sd1) + (18'(walker_b) + rr);
    end
    idx32 = 32'(idx);
    key   = {walker_x[43:0], 20'b0} ^ {32'b0, idx32};
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // The result register takes a new result when it is empty or being drained.
  logic emit;
  assign emit = (state == S_KEY) && (!out_valid || out_ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      rng[0]     <= '0;
      rng[1]     <= '0;
      rng[2]     <= '0;
      rng[3]     <= '0;
      walker_x   <= '0;
      walker_a   <= '0;
      walker_b   <= '0;
      last_key   <= '0;
      jump_count <= '0;
      ph         <= '0;
      seed_idx   <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            is_start <= q_item.is_start;
            ph       <= '0;
            if (q_item.is_start) begin
              mx       <= xs30((q_item.key ^ SEED_SALT) + GOLD);
              seed_idx <= '0;
              state    <= S_MUL1;
            end else begin
              u      <= rout[63:11];
              rng[0] <= n0;
              rng[1] <= n1;
              rng[2] <= n2 ^ (rng[1] << 17);
              rng[3] <= {n3[18:0], n3[63:19]};
              state  <= S_CLASS;
            end
          end
        end
        S_MUL1: begin
          if (ph == 3'd3) begin
            mx    <= z2 ^ (z2 >> 27);
            ph    <= '0;
            state <= S_MUL2;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_MUL2: begin
          if (ph == 3'd3) begin
            ph <= '0;
            if (seed_idx == '0) begin
              z_run <= smix;
            end else begin
              rng[2'(seed_idx - 3'd1)] <= smix;
            end
            if (seed_idx == 3'd4) begin
              walker_x   <= '0;
              walker_a   <= '0;
              walker_b   <= '0;
              jump_count <= '0;
              dir        <= DIR_FORWARD;
              state      <= S_KEY;
            end else begin
              state <= S_PREP;
            end
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_PREP: begin
          z_run    <= z_run + GOLD;
          mx       <= xs30(z_run + GOLD2);
          seed_idx <= seed_idx + 1'b1;
          state    <= S_MUL1;
        end
        S_CLASS: begin
          if ({1'b0, u} < forward_threshold) begin
            dir   <= DIR_FORWARD;
            state <= S_MOVE;
          end else if ({1'b0, u} < backward_threshold) begin
            dir   <= DIR_BACKWARD;
            state <= S_MOVE;
          end else begin
            mx    <= {10'b0, ({1'b0, u} - backward_threshold)};
            ph    <= '0;
            state <= S_MULK;
          end
        end
        S_MULK: begin
          if (ph == 3'd4) begin
            dir   <= dir_t;
            state <= S_MOVE;
          end else begin
            ph <= ph + 1'b1;
          end
        end
        S_MOVE: begin
          if (dir == DIR_FORWARD) begin
            walker_x <= walker_x + 64'd1;
          end else if (dir == DIR_BACKWARD) begin
            walker_x <= walker_x - 64'd1;
          end
          walker_a <= a_next;
          walker_b <= b_next;
          if (jump_count != COUNT_MAX) begin
            jump_count <= jump_count + 48'd1;
          end
          state <= S_KEY;
        end
        S_KEY: begin
          if (emit) begin
            last_key <= key;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Multiplier pipeline and result payload.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    acc  <= (ph == 3'd0) ? '0 : acc_sum;
    if (emit) begin
      position_x   <= $signed(walker_x);
      coord_a      <= walker_a[4:0];
      coord_b      <= walker_b[4:0];
      direction    <= dir;
      site_key     <= key;
      site_changed <= is_start || (key != last_key);
      step_count   <= jump_count;
    end
  end

endmodule

FILE: rtl/confined_lattice_walker_step_unit.sv
// A step along the axis is classified and moved in the back end; a transverse
// draw also passes through the shared 32x32 multiplier that serves the splitmix
// seeding and the transverse scaling. Items enter through the input stage and
// queue, which take new items while the back end handles one item at a time.
// Reset: rst is synchronous, active high; it clears the queue, the generator,
// the walker and loads the register defaults.
// ----------------------------------------------------------------------------
// confined_lattice_walker_step_unit: biased lattice walker in a channel
// Front stage and queue take items in; the back end seeds, steps and moves.
// ----------------------------------------------------------------------------
module confined_lattice_walker_step_unit import clws_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = CLWS_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [63:0]            walker_key,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [63:0]     position_x,
  output logic signed [4:0]      coord_a,
  output logic signed [4:0]      coord_b,
  output logic [2:0]             direction,
  output logic [63:0]            site_key,
  output logic                   site_changed,
  output logic [47:0]            step_count
);

  logic    push;
  logic    push_ready;
  q_item_t push_item;
  logic    q_valid;
  logic    q_pop;
  q_item_t q_item;

  // Input stage.
  clws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .walker_key (walker_key),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Decoupling queue.
  clws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  // Execution back end.
  clws_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .position_x   (position_x),
    .coord_a      (coord_a),
    .coord_b      (coord_b),
    .direction    (direction),
    .site_key     (site_key),
    .site_changed (site_changed),
    .step_count   (step_count)
  );

endmodule

FILE: rtl/clws_checker.sv
// ----------------------------------------------------------------------------
// clws_checker: port-level checks of the walker step unit
// Watches the result channel and the values reported for a fresh walker.
// ----------------------------------------------------------------------------
module clws_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [63:0] position_x,
  input logic signed [4:0]  coord_a,
  input logic signed [4:0]  coord_b,
  input logic [2:0]         direction,
  input logic               site_changed,
  input logic [47:0]        step_count
);

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before its transfer");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

  // A fresh walker always reports a new site.
  a_start_changed: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_count == 48'd0 |-> site_changed)
    else $error("start result without site change");

  // A fresh walker sits at the origin with direction zero.
  a_start_origin: assert property (@(posedge clk) disable iff (rst)
    out_valid && step_count == 48'd0 |->
      position_x == 64'sd0 && coord_a == 5'sd0 && coord_b == 5'sd0 && direction == 3'd0)
    else $error("start result away from the origin");

endmodule

bind confined_lattice_walker_step_unit clws_checker u_clws_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .position_x   (position_x),
  .coord_a      (coord_a),
  .coord_b      (coord_b),
  .direction    (direction),
  .site_changed (site_changed),
  .step_count   (step_count)
);
